// ===== hdl/spq_pkg.sv =====
// Package: types, codes and constants shared by the sorted priority queue files.
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam logic [7:0] SPACE_CHAR = 8'd32;

    typedef enum logic {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic               req_type;
        logic [7:0]         item_data;
        logic signed [15:0] item_priority;
    } t_req;

    typedef struct packed {
        logic [7:0] out_data;
        logic [1:0] status;
        logic [4:0] occupancy;
    } t_rsp;

    // One stored entry as it moves along the cell chain.
    typedef struct packed {
        logic               valid;
        logic [7:0]         data;
        logic signed [15:0] prio;
    } t_entry;

    // Broadcast command to every cell.
    typedef struct packed {
        logic               enq;
        logic               deq;
        logic [7:0]         data;
        logic signed [15:0] prio;
    } t_cmd;

endpackage

// ===== hdl/spq_cell.sv =====
// Module: one cell of the sorted chain, holding a single entry.
module spq_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spq_pkg::t_cmd   i_cmd,
    input  spq_pkg::t_entry i_left,
    input  logic           i_left_before,
    input  spq_pkg::t_entry i_right,
    output spq_pkg::t_entry o_entry,
    output logic           o_before
);
    import spq_pkg::*;

    logic               r_valid;
    logic [7:0]         r_data;
    logic signed [15:0] r_prio;
    t_entry             n_entry;

    // New item goes at or before this cell; the head only yields to a strictly smaller one.
    always_comb begin
        if (IS_HEAD) begin
            o_before = !r_valid || (i_cmd.prio < r_prio);
        end else begin
            o_before = !r_valid || (i_cmd.prio <= r_prio);
        end
    end

    always_comb begin
        n_entry = '{valid: r_valid, data: r_data, prio: r_prio};
        if (i_cmd.deq) begin
            n_entry = i_right;
        end else if (i_cmd.enq && o_before) begin
            if (i_left_before) begin
                n_entry = i_left;
            end else begin
                n_entry = '{valid: 1'b1, data: i_cmd.data, prio: i_cmd.prio};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
        r_data <= n_entry.data;
        r_prio <= n_entry.prio;
    end

    assign o_entry = '{valid: r_valid, data: r_data, prio: r_prio};

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// Module: top level of the sorted priority queue built as a chain of cells.
//
//   channel | valid       | stall        | payload
//   --------+-------------+--------------+------------------------------
//   request | i_in_valid  | o_in_stall   | i_in  (t_req: type, data, prio)
//   result  | o_out_valid | i_out_stall  | o_out (t_rsp: data, status, occ)
//
// Operation: all cells compare the new priority against their own entry and shift
//   to or from a neighbor in the same cycle that the transaction is accepted.
// A new transaction may follow in the very next cycle unless the request side is stalled.
// Reset: synchronous, active low; clears all valid bits, the count and the output side.
// Stalls: a result waits in the output register; a second one lands in a skid register,
//   and only while the skid register is full is the request side stalled.
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  spq_pkg::t_req i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output spq_pkg::t_rsp o_out
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Cell chain wiring.
    t_entry w_entry [DEPTH];
    logic   w_before [DEPTH];
    t_cmd   w_cmd;

    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_full;
    logic             w_empty;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [31:0]      w_count_ext;
    t_rsp             w_rsp;

    logic r_out_valid;
    t_rsp r_out;
    logic r_skid_valid;
    t_rsp r_skid;

    assign w_in_acc  = i_in_valid && !r_skid_valid;
    assign w_out_acc = r_out_valid && !i_out_stall;
    assign w_full    = w_entry[DEPTH-1].valid;
    assign w_empty   = !w_entry[0].valid;

    // Broadcast the accepted transaction; drop enqueues on a full chain and dequeues on an empty one.
    always_comb begin
        w_cmd.enq  = w_in_acc && (i_in.req_type == REQ_ENQ) && !w_full;
        w_cmd.deq  = w_in_acc && (i_in.req_type == REQ_DEQ) && !w_empty;
        w_cmd.data = i_in.item_data;
        w_cmd.prio = i_in.item_priority;
    end

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_entry w_left;
        logic   w_left_before;
        t_entry w_right;

        if (gi == 0) begin : g_first
            assign w_left        = '0;
            assign w_left_before = 1'b0;
        end else begin : g_mid
            assign w_left        = w_entry[gi-1];
            assign w_left_before = w_before[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_entry[gi+1];
        end

        spq_cell #(
            .IS_HEAD(gi == 0)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_left       (w_left),
            .i_left_before(w_left_before),
            .i_right      (w_right),
            .o_entry      (w_entry[gi]),
            .o_before     (w_before[gi])
        );
    end

    // Occupancy after the transaction and the result it produces.
    always_comb begin
        n_count = r_count;
        if (w_cmd.enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_cmd.deq) begin
            n_count = r_count - CNT_W'(1);
        end
        w_count_ext = 32'(n_count);

        w_rsp.occupancy = w_count_ext[4:0];
        w_rsp.out_data  = 8'd0;
        w_rsp.status    = ST_ENQUEUED;
        if (i_in.req_type == REQ_ENQ) begin
            if (w_full) begin
                w_rsp.status = ST_FULL;
            end
        end else if (w_empty) begin
            w_rsp.out_data = SPACE_CHAR;
            w_rsp.status   = ST_EMPTY;
        end else begin
            w_rsp.out_data = w_entry[0].data;
            w_rsp.status   = ST_DEQUEUED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Output register plus skid register: advance the skid entry when the output frees up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_acc || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_in_acc;
                r_out       <= w_rsp;
            end
        end else if (w_in_acc) begin
            r_skid_valid <= 1'b1;
            r_skid       <= w_rsp;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Expected valid pattern: the first r_count cells hold entries.
    logic [DEPTH-1:0] w_valid_vec;
    logic [DEPTH-1:0] w_valid_exp;
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_valid_vec[i] = w_entry[i].valid;
            w_valid_exp[i] = (CNT_W'(i) < r_count);
        end
    end

    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid_vec == w_valid_exp)
        else $error("cell valid bits disagree with entry count");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_entry[1].valid |-> (w_entry[0].prio <= w_entry[1].prio))
        else $error("head and second cell out of priority order");

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    a_deq_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.deq |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("dequeue did not lower the entry count");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.req_type == REQ_ENQ) && w_full) |=> $stable(r_count))
        else $error("rejected enqueue changed the entry count");

endmodule

// ===== sim/sorted_priority_queue_test.sv =====
// Self-checking testbench for sorted_priority_queue, with its own ordered-list predictor.
`timescale 1ns / 1ps

module sorted_priority_queue_test;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int QUEUE_DEPTH     = spq_pkg::DEPTH_DEFAULT;
    localparam int IDLE_PCT        = 19;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int SETTLE_CYCLES   = 20;
    // Longest correct stretch with no transaction is the receiver hold-off plus
    // a run of random stalls; allow many times that before declaring a hang.
    localparam int HANG_LIMIT      = 2000;

    // Predict every result from an ordered copy of the stored entries and
    // hold the expected results in arrival order.
    class spq_scoreboard;
        typedef struct packed {
            logic [7:0]         data;
            logic signed [15:0] prio;
        } t_slot;

        t_slot         held_entries[$];
        spq_pkg::t_rsp awaited_results[$];
        int            capacity;
        int            mismatches;
        int            results_seen;

        function new(int depth);
            capacity     = depth;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        // Apply one accepted request to the ordered list and queue its result.
        function void note_request(spq_pkg::t_req req);
            spq_pkg::t_rsp want;
            t_slot         slot;
            int            pos;
            want.out_data = 8'd0;
            if (req.req_type == spq_pkg::REQ_ENQ) begin
                if (held_entries.size() >= capacity) begin
                    want.status = spq_pkg::ST_FULL;
                end else begin
                    slot.data = req.item_data;
                    slot.prio = req.item_priority;
                    // Only a strictly smaller priority takes the head; ties queue
                    // up after the head and before the first equal-or-greater entry.
                    if (held_entries.size() == 0 || slot.prio < held_entries[0].prio) begin
                        pos = 0;
                    end else begin
                        pos = 1;
                        while (pos < held_entries.size() && slot.prio > held_entries[pos].prio)
                            pos++;
                    end
                    held_entries.insert(pos, slot);
                    want.status = spq_pkg::ST_ENQUEUED;
                end
            end else if (held_entries.size() == 0) begin
                want.out_data = spq_pkg::SPACE_CHAR;
                want.status   = spq_pkg::ST_EMPTY;
            end else begin
                slot          = held_entries.pop_front();
                want.out_data = slot.data;
                want.status   = spq_pkg::ST_DEQUEUED;
            end
            want.occupancy = 5'(held_entries.size());
            awaited_results.push_back(want);
        endfunction

        task report(string msg);
            $display("[%0t] result %0d mismatch: %s", $realtime, results_seen, msg);
            mismatches++;
        endtask

        // Compare one accepted result, field by field, with the oldest expectation.
        task check_result(spq_pkg::t_rsp got);
            spq_pkg::t_rsp want;
            results_seen++;
            if (awaited_results.size() == 0) begin
                report($sformatf("unexpected result data=%0d status=%0d occupancy=%0d",
                                 got.out_data, got.status, got.occupancy));
                return;
            end
            want = awaited_results.pop_front();
            if (got.out_data !== want.out_data)
                report($sformatf("out_data %0d, want %0d", got.out_data, want.out_data));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.occupancy !== want.occupancy)
                report($sformatf("occupancy %0d, want %0d", got.occupancy, want.occupancy));
        endtask
    endclass

    // Drive every input to a known value from time zero.
    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    spq_pkg::t_req i_in        = '0;
    logic          i_out_stall = 1'b0;
    logic          o_in_stall;
    logic          o_out_valid;
    spq_pkg::t_rsp o_out;

    // Written by the request side only; read by the result side.
    bit            no_idle_stretch   = 1'b0;
    int            hold_off_requests = 0;

    spq_scoreboard queue_check = new(QUEUE_DEPTH);

    sorted_priority_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic spq_pkg::t_req make_req(spq_pkg::t_req_type kind, logic [7:0] data,
                                               logic signed [15:0] prio);
        spq_pkg::t_req req;
        req.req_type      = kind;
        req.item_data     = data;
        req.item_priority = prio;
        return req;
    endfunction

    // Draw a request: mostly small priorities so that ties are common, some from
    // the full range and a few at the two extremes. Dequeues carry random junk.
    function automatic spq_pkg::t_req random_request(int enq_pct);
        spq_pkg::t_req req;
        int            pick;
        req.req_type  = ($urandom_range(99) < enq_pct) ? spq_pkg::REQ_ENQ : spq_pkg::REQ_DEQ;
        req.item_data = 8'($urandom);
        pick          = $urandom_range(9);
        if (pick < 5) begin
            req.item_priority = 16'($urandom_range(8));
            req.item_priority = req.item_priority - 16'sd4;
        end else if (pick < 8) begin
            req.item_priority = 16'($urandom);
        end else if (pick == 8) begin
            req.item_priority = 16'sh8000;
        end else begin
            req.item_priority = 16'sh7FFF;
        end
        return req;
    endfunction

    // Offer one transaction, idling at random first, and hold it until accepted.
    // Valid stays high into the next transaction unless an idle cycle is drawn.
    task automatic send_request(spq_pkg::t_req req);
        while (!no_idle_stretch && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task automatic run_phase(int count, int enq_pct);
        repeat (count)
            send_request(random_request(enq_pct));
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (queue_check.pending() != 0)
            @(posedge i_clk);
    endtask

    // Request side: reset, directed cases, then random phases.
    initial begin : request_side
        logic signed [15:0] fill_prio [11];
        fill_prio = '{16'sd1, -16'sd1, 16'sd0, 16'sh7FFF, 16'sd1, -16'sd100,
                      16'sd100, 16'sh8000, 16'sd3, 16'sd3, 16'sd2};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Dequeue from the empty queue: expect a space and empty status.
        send_request(make_req(spq_pkg::REQ_DEQ, 8'hFF, 16'sh7FFF));
        // Extremes of data and priority, a tie with the head, a new head,
        // and a tie at the most negative priority.
        send_request(make_req(spq_pkg::REQ_ENQ, 8'h00, 16'sd0));
        send_request(make_req(spq_pkg::REQ_ENQ, 8'hFF, 16'sd0));
        send_request(make_req(spq_pkg::REQ_ENQ, 8'h5A, 16'sh7FFF));
        send_request(make_req(spq_pkg::REQ_ENQ, 8'hA5, 16'sh8000));
        send_request(make_req(spq_pkg::REQ_ENQ, 8'h3C, 16'sh8000));
        // Fill the queue to capacity with a mix of ties and extremes.
        foreach (fill_prio[k])
            send_request(make_req(spq_pkg::REQ_ENQ, 8'(8'h10 + k), fill_prio[k]));
        // Enqueue into the full queue: expect a rejection.
        send_request(make_req(spq_pkg::REQ_ENQ, 8'hC3, -16'sd7));
        send_request(make_req(spq_pkg::REQ_DEQ, 8'h00, 16'sh0000));
        send_request(make_req(spq_pkg::REQ_DEQ, 8'h77, 16'sh1234));

        // Pause the sender until the queue has answered everything.
        wait_drained();

        run_phase(110, 75);

        // Hold off the receiver while requests keep coming, so the output and
        // skid registers fill and the request side stalls.
        hold_off_requests <= hold_off_requests + 1;
        run_phase(90, 60);

        // Stretch with no idling on either side.
        no_idle_stretch <= 1'b1;
        run_phase(100, 50);
        no_idle_stretch <= 1'b0;

        wait_drained();

        hold_off_requests <= hold_off_requests + 1;
        run_phase(60, 85);
        run_phase(90, 25);

        // Drain, then let a few cycles pass to catch any stray result.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (queue_check.mismatches == 0 && queue_check.pending() == 0) begin
            $display("sorted_priority_queue regression: pass");
        end else begin
            $display("sorted_priority_queue regression: fail");
        end
        $finish;
    end

    // Result side: random stalls, none during the no-idle stretch, and a long
    // hold-off counted here whenever the request side asks for one.
    initial begin : result_side
        int hold_offs_done;
        hold_offs_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_requests != hold_offs_done) begin
                hold_offs_done++;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge i_clk);
            end else if (no_idle_stretch) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Sample both channels at the edge; check results before noting the new
    // request so a stray result is never matched against it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0)
                queue_check.check_result(o_out);
            if (i_in_valid === 1'b1 && o_in_stall === 1'b0)
                queue_check.note_request(i_in);
        end
    end

    // Count cycles with no transaction on either channel; end the run on a hang.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < HANG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_stall === 1'b0)
                    || (o_out_valid === 1'b1 && i_out_stall === 1'b0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[%0t] no transaction for %0d cycles", $realtime, HANG_LIMIT);
        $display("sorted_priority_queue regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
sim/sorted_priority_queue_test.sv
